>>> src/pncm_pkg.sv
// Shared constants, codes and types for the palette nearest-colour match unit.
package pncm_pkg;

    // Palette geometry
    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

    // Colour and distance widths
    localparam int CHAN_W   = 8;
    localparam int COLOUR_W = 3 * CHAN_W;
    localparam int SQ_W     = 2 * CHAN_W;
    localparam int DIST_W   = SQ_W + 2;
    localparam logic [DIST_W-1:0] DIST_LIMIT = DIST_W'(1024);

    // Result field widths
    localparam int MATCH_W = 8;
    localparam logic [MATCH_W-1:0] NO_MATCH_INDEX = MATCH_W'(255);

    // Item modes
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MATCH  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

    // Register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_PRESENT = 1'b0;

    // Tag that travels with one palette entry through the scan pipeline
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
    } t_scan_tag;

endpackage

>>> src/pncm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pncm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/pncm_dist.sv
// Shared distance unit: squared RGB distance of one palette entry, one result a cycle.
module pncm_dist (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [pncm_pkg::COLOUR_W-1:0] i_entry,
    input  logic [pncm_pkg::COLOUR_W-1:0] i_query,
    input  pncm_pkg::t_scan_tag         i_tag,
    output logic [pncm_pkg::DIST_W-1:0] o_dist,
    output pncm_pkg::t_scan_tag         o_tag
);

    import pncm_pkg::*;

    logic [CHAN_W-1:0] e_ch [3];
    logic [CHAN_W-1:0] q_ch [3];
    logic [CHAN_W-1:0] diff [3];
    logic [SQ_W-1:0]   sq   [3];
    logic [DIST_W-1:0] sum;
    logic [DIST_W-1:0] r_dist;
    t_scan_tag         r_tag;

    // Per-channel absolute difference and square
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            e_ch[c] = i_entry[c*CHAN_W +: CHAN_W];
            q_ch[c] = i_query[c*CHAN_W +: CHAN_W];
            diff[c] = (e_ch[c] > q_ch[c]) ? (e_ch[c] - q_ch[c]) : (q_ch[c] - e_ch[c]);
            sq[c]   = SQ_W'(diff[c]) * SQ_W'(diff[c]);
        end
        sum = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);
    end

    // Result register; tag valid is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.vld <= 1'b0;
        end else begin
            r_tag.vld <= i_tag.vld;
        end
        r_tag.idx <= i_tag.idx;
        r_dist    <= sum;
    end

    assign o_dist = r_dist;
    assign o_tag  = r_tag;

endmodule

>>> src/palette_nearest_colour_match_unit.sv
// Top level: palette store, scan sequencer, best-match tracking and register port.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+--------------------------------------------
//  command  | start in, busy out             | i_mode, i_entry_index, i_red/green/blue_value,
//           |                                | i_query_colour, i_native_index
//  result   | o_done (one-cycle strobe)      | o_match_index, o_packed_colour
//  register | psel/penable/pwrite/pready     | paddr, pwdata, prdata (palette_present)
//
// A write beat is stored at its accept edge; busy stays low.
// A match query reads one palette entry per cycle through the single RAM read port
// and the shared distance unit.
// A lookup query passes through the registered RAM read and then the result register.
// Reset clears the entry valid bits at once, so no clearing pass is needed.
// The result strobe lasts one cycle and cannot be held off.
module palette_nearest_colour_match_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [pncm_pkg::MODE_W-1:0]         i_mode,
    input  logic [7:0]                          i_entry_index,
    input  logic [15:0]                         i_red_value,
    input  logic [15:0]                         i_green_value,
    input  logic [15:0]                         i_blue_value,
    input  logic [pncm_pkg::COLOUR_W-1:0]       i_query_colour,
    input  logic [31:0]                         i_native_index,
    // result channel
    output logic                                o_done,
    output logic [pncm_pkg::MATCH_W-1:0]        o_match_index,
    output logic [pncm_pkg::COLOUR_W-1:0]       o_packed_colour,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pncm_pkg::PADDR_W-1:0]        paddr,
    input  logic [pncm_pkg::PDATA_W-1:0]        pwdata,
    output logic [pncm_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    import pncm_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DONE  = 3'd3;
    localparam logic [2:0] ST_LOOK  = 3'd4;

    logic [2:0]                r_state, n_state;
    logic                      r_present;
    logic [PALETTE_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]          r_addr;
    logic [COLOUR_W-1:0]       r_query;
    logic                      r_rd_ok;
    t_scan_tag                 r_s1;
    logic [DIST_W-1:0]         r_best_dist;
    logic [IDX_W-1:0]          r_best_idx;
    logic                      r_best_hit;
    logic                      r_done;
    logic [MATCH_W-1:0]        r_match;
    logic [COLOUR_W-1:0]       r_colour;

    logic                      accept;
    logic                      wr_en;
    logic [IDX_W-1:0]          lookup_idx;
    logic [IDX_W-1:0]          rd_addr;
    logic [COLOUR_W-1:0]       rd_data;
    logic [COLOUR_W-1:0]       entry;
    logic [DIST_W-1:0]         s2_dist;
    t_scan_tag                 s2_tag;
    logic                      better;
    logic                      cfg_wr;

    // Command decode
    assign accept     = start && !busy;
    assign busy       = (r_state != ST_IDLE);
    assign wr_en      = accept && (i_mode == MODE_WRITE)
                        && (32'(i_entry_index) < PALETTE_ENTRIES);
    assign lookup_idx = (i_native_index > 32'(LAST_IDX)) ? LAST_IDX
                                                         : i_native_index[IDX_W-1:0];
    assign rd_addr    = (r_state == ST_IDLE) ? lookup_idx : r_addr;

    // Palette store
    pncm_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (i_entry_index[IDX_W-1:0]),
        .i_wdata ({i_red_value[15:8], i_green_value[15:8], i_blue_value[15:8]}),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Entry valid bits: an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[i_entry_index[IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok <= r_valid[rd_addr];
    end

    assign entry = r_rd_ok ? rd_data : '0;

    // Scan tag alongside the RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else begin
            r_s1.vld <= (r_state == ST_SCAN);
        end
        r_s1.idx <= r_addr;
    end

    // Shared distance unit
    pncm_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (entry),
        .i_query (r_query),
        .i_tag   (r_s1),
        .o_dist  (s2_dist),
        .o_tag   (s2_tag)
    );

    assign better = s2_tag.vld && (s2_dist < r_best_dist);

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_mode == MODE_MATCH)) begin
                    n_state = ST_SCAN;
                end else if (accept && (i_mode == MODE_LOOKUP)) begin
                    n_state = ST_LOOK;
                end
            end
            ST_SCAN: begin
                if (r_addr == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (s2_tag.vld && (s2_tag.idx == LAST_IDX)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            ST_LOOK: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Scan address and query latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (r_state == ST_IDLE) begin
            r_addr <= '0;
        end else if (r_state == ST_SCAN) begin
            r_addr <= r_addr + 1'b1;
        end
        if (accept) begin
            r_query <= i_query_colour;
        end
    end

    // Best match so far; first minimum wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_dist <= DIST_LIMIT;
            r_best_hit  <= 1'b0;
        end else if (accept) begin
            r_best_dist <= DIST_LIMIT;
            r_best_hit  <= 1'b0;
        end else if (better) begin
            r_best_dist <= s2_dist;
            r_best_hit  <= 1'b1;
        end
        if (better) begin
            r_best_idx <= s2_tag.idx;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == ST_DONE) || (r_state == ST_LOOK);
        end
        if (r_state == ST_DONE) begin
            r_match  <= !r_present ? '0
                      : (r_best_hit ? MATCH_W'(r_best_idx) : NO_MATCH_INDEX);
            r_colour <= '0;
        end else begin
            r_match  <= '0;
            r_colour <= r_present ? entry : '0;
        end
    end

    assign o_done          = r_done;
    assign o_match_index   = r_match;
    assign o_packed_colour = r_colour;

    // Register port
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
        end else if (cfg_wr && (paddr[2] == REG_PRESENT)) begin
            r_present <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PRESENT) ? PDATA_W'(r_present) : '0;

`ifndef SYNTHESIS
    // Result strobe only follows the finishing states
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == ST_DONE || r_state == ST_LOOK))
        else $error("result strobe without a finished query");

    // Without a palette both result fields are zero
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_present) |-> (o_match_index == '0 && o_packed_colour == '0))
        else $error("non-zero result with palette absent");

    // A result carries either an index or a colour, never both
    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (o_match_index == '0 || o_packed_colour == '0))
        else $error("result carries both index and colour");

    // Best distance never rises above the match limit
    a_best_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_dist <= DIST_LIMIT)
        else $error("best distance above limit");

    // Distance unit only carries entries during a scan
    a_scan_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_tag.vld |-> (r_state == ST_SCAN || r_state == ST_DRAIN))
        else $error("distance result outside a scan");
`endif

endmodule

>>> tb/sv/palette_nearest_colour_match_unit_tb.sv
// Self-checking testbench for the palette colour match unit: directed table, then random beats.
module palette_nearest_colour_match_unit_tb;
    import pncm_pkg::*;

    localparam logic [MODE_W-1:0]  MODE_UNUSED   = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_PRESENT  = PADDR_W'(4 * REG_PRESENT);
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = PADDR_W'(4);
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RANDOM_BEATS  = 1830;
    localparam int PHASES        = 9;

    typedef enum logic {ROW_BEAT, ROW_REG} t_row_kind;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [7:0]          entry;
        logic [15:0]         red;
        logic [15:0]         green;
        logic [15:0]         blue;
        logic [COLOUR_W-1:0] query;
        logic [31:0]         native;
    } t_command;

    typedef struct packed {
        logic [MATCH_W-1:0]  match_idx;
        logic [COLOUR_W-1:0] colour;
    } t_answer;

    typedef struct packed {
        t_row_kind           kind;
        t_command            cmd;
        logic                known;
        t_answer             answer;
        logic [PADDR_W-1:0]  addr;
        logic [PDATA_W-1:0]  wdata;
    } t_stim_row;

    // Clock, reset and block inputs, all known from time zero
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                start          = 1'b0;
    logic [MODE_W-1:0]   i_mode         = '0;
    logic [7:0]          i_entry_index  = '0;
    logic [15:0]         i_red_value    = '0;
    logic [15:0]         i_green_value  = '0;
    logic [15:0]         i_blue_value   = '0;
    logic [COLOUR_W-1:0] i_query_colour = '0;
    logic [31:0]         i_native_index = '0;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [PADDR_W-1:0]  paddr          = '0;
    logic [PDATA_W-1:0]  pwdata         = '0;
    logic                busy;
    logic                o_done;
    logic [MATCH_W-1:0]  o_match_index;
    logic [COLOUR_W-1:0] o_packed_colour;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Mirror of the palette and the presence flag
    logic [CHAN_W-1:0] mirror_red   [PALETTE_ENTRIES];
    logic [CHAN_W-1:0] mirror_green [PALETTE_ENTRIES];
    logic [CHAN_W-1:0] mirror_blue  [PALETTE_ENTRIES];
    logic              mirror_present;
    t_answer           awaited_answers[$];
    int                errors      = 0;
    int                cycle_count = 0;
    int                idle_pct    = 7;

    palette_nearest_colour_match_unit dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("palette_nearest_colour_match_unit_tb failed");
            $finish;
        end
    end

    // Apply one accepted beat to the mirror; queries queue their answer
    task automatic absorb_command(input t_command cmd, input logic known, input t_answer typed);
        t_answer          ans;
        logic [IDX_W-1:0] slot;
        int               best_span;
        int               best_slot;
        int               dr, dg, db, span;
        ans = '0;
        case (cmd.mode)
            MODE_WRITE: begin
                if (int'(cmd.entry) < PALETTE_ENTRIES) begin
                    mirror_red[cmd.entry]   = cmd.red[15:8];
                    mirror_green[cmd.entry] = cmd.green[15:8];
                    mirror_blue[cmd.entry]  = cmd.blue[15:8];
                end
            end
            MODE_MATCH: begin
                if (mirror_present) begin
                    // scan in order; strict compare keeps the first minimum
                    best_span = int'(DIST_LIMIT);
                    best_slot = int'(NO_MATCH_INDEX);
                    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                        dr   = int'(cmd.query[23:16]) - int'(mirror_red[i]);
                        dg   = int'(cmd.query[15:8]) - int'(mirror_green[i]);
                        db   = int'(cmd.query[7:0]) - int'(mirror_blue[i]);
                        span = dr * dr + dg * dg + db * db;
                        if (span < best_span) begin
                            best_span = span;
                            best_slot = i;
                        end
                    end
                    ans.match_idx = MATCH_W'(best_slot);
                end
                awaited_answers.push_back(known ? typed : ans);
            end
            MODE_LOOKUP: begin
                if (mirror_present) begin
                    // index saturates at the last entry
                    slot = (cmd.native > 32'(LAST_IDX)) ? LAST_IDX : cmd.native[IDX_W-1:0];
                    ans.colour = {mirror_red[slot], mirror_green[slot], mirror_blue[slot]};
                end
                awaited_answers.push_back(known ? typed : ans);
            end
            default: ;
        endcase
    endtask

    // Present one beat, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_command(input t_command cmd, input logic known, input t_answer typed);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_mode         <= cmd.mode;
        i_entry_index  <= cmd.entry;
        i_red_value    <= cmd.red;
        i_green_value  <= cmd.green;
        i_blue_value   <= cmd.blue;
        i_query_colour <= cmd.query;
        i_native_index <= cmd.native;
        do @(posedge i_clk); while (busy !== 1'b0);
        absorb_command(cmd, known, typed);
    endtask

    // Drop start and wait until every awaited answer is in and the block is quiet
    task automatic settle_for_config();
        start <= 1'b0;
        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register access: setup cycle, then access cycle until pready
    task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (wr && addr == ADDR_PRESENT)
            mirror_present = data[0];
        if (!wr && addr == ADDR_PRESENT && prdata !== PDATA_W'(mirror_present)) begin
            errors++;
            $display("%0t: palette_present readback expected %0h, actual %0h",
                     $time, PDATA_W'(mirror_present), prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Register write while idle, then read palette_present back
    task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        settle_for_config();
        reg_access(1'b1, addr, data);
        reg_access(1'b0, ADDR_PRESENT, '0);
    endtask

    function automatic t_stim_row beat_row(
        logic [MODE_W-1:0] mode, logic [7:0] entry,
        logic [15:0] red, logic [15:0] green, logic [15:0] blue,
        logic [COLOUR_W-1:0] query, logic [31:0] native,
        logic known, logic [MATCH_W-1:0] exp_idx, logic [COLOUR_W-1:0] exp_colour);
        t_stim_row r;
        r        = '0;
        r.kind   = ROW_BEAT;
        r.cmd    = '{mode, entry, red, green, blue, query, native};
        r.known  = known;
        r.answer = '{exp_idx, exp_colour};
        return r;
    endfunction

    function automatic t_stim_row reg_row(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        t_stim_row r;
        r       = '0;
        r.kind  = ROW_REG;
        r.addr  = addr;
        r.wdata = data;
        return r;
    endfunction

    // Small random step around a stored channel, clamped to the byte range
    function automatic logic [CHAN_W-1:0] nudge(logic [CHAN_W-1:0] v);
        int off;
        int n;
        off = $urandom_range(0, 40);
        n   = int'(v) + off - 20;
        if (n < 0)   n = 0;
        if (n > 255) n = 255;
        return CHAN_W'(n);
    endfunction

    // Random beat: palette writes, queries near stored colours, lookups, some noise
    function automatic t_command random_command();
        t_command c;
        int       pick;
        int       src;
        c.mode   = MODE_UNUSED;
        c.entry  = 8'($urandom);
        c.red    = 16'($urandom);
        c.green  = 16'($urandom);
        c.blue   = 16'($urandom);
        c.query  = COLOUR_W'($urandom);
        c.native = $urandom;
        pick     = $urandom_range(0, 99);
        src      = $urandom_range(0, PALETTE_ENTRIES - 1);
        if (pick < 35) begin
            c.mode = MODE_WRITE;
            // copy a stored colour now and then so ties turn up
            if ($urandom_range(0, 4) == 0) begin
                c.red[15:8]   = mirror_red[src];
                c.green[15:8] = mirror_green[src];
                c.blue[15:8]  = mirror_blue[src];
            end
        end else if (pick < 65) begin
            c.mode = MODE_MATCH;
            if ($urandom_range(0, 9) < 6)
                c.query = {nudge(mirror_red[src]), nudge(mirror_green[src]),
                           nudge(mirror_blue[src])};
        end else if (pick < 93) begin
            c.mode = MODE_LOOKUP;
            case ($urandom_range(0, 6))
                0:       ;
                1:       c.native = $urandom_range(256, 1023);
                default: c.native = $urandom_range(0, PALETTE_ENTRIES - 1);
            endcase
        end
        return c;
    endfunction

    // Result side: every strobe is checked against the oldest awaited answer
    always @(posedge i_clk) begin : result_check
        t_answer want;
        if (i_rst_n && o_done === 1'b1) begin
            if (awaited_answers.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, actual match_index %0d colour %06h",
                         $time, o_match_index, o_packed_colour);
            end else begin
                want = awaited_answers.pop_front();
                if (o_match_index !== want.match_idx) begin
                    errors++;
                    $display("%0t: match_index expected %0d, actual %0d",
                             $time, want.match_idx, o_match_index);
                end
                if (o_packed_colour !== want.colour) begin
                    errors++;
                    $display("%0t: packed_colour expected %06h, actual %06h",
                             $time, want.colour, o_packed_colour);
                end
            end
        end
    end

    // Stimulus
    initial begin
        t_stim_row          directed[$];
        t_command           cmd;
        logic [PDATA_W-1:0] wdata;
        int                 beats;
        int                 phase;
        int                 phase_end;

        for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            mirror_red[i]   = '0;
            mirror_green[i] = '0;
            mirror_blue[i]  = '0;
        end
        mirror_present = 1'b0;

        // palette absent out of reset: queries answer zero, writes still land
        directed.push_back(beat_row(MODE_LOOKUP, 8'd0, 16'h0, 16'h0, 16'h0, 24'h0, 32'd0,
                                    1'b1, 8'd0, 24'h0));
        directed.push_back(beat_row(MODE_MATCH, 8'd0, 16'h0, 16'h0, 16'h0, 24'h0, 32'd0,
                                    1'b1, 8'd0, 24'h0));
        directed.push_back(beat_row(MODE_WRITE, 8'd0, 16'hFFFF, 16'h00FF, 16'h8000, 24'hFFFFFF,
                                    32'hFFFF_FFFF, 1'b0, 8'd0, 24'h0));
        directed.push_back(beat_row(MODE_WRITE, 8'd255, 16'h1234, 16'hABCD, 16'h00FF, 24'h0,
                                    32'd0, 1'b0, 8'd0, 24'h0));
        directed.push_back(beat_row(MODE_LOOKUP, 8'd0, 16'h0, 16'h0, 16'h0, 24'h0, 32'd0,
                                    1'b1, 8'd0, 24'h0));
        directed.push_back(reg_row(ADDR_PRESENT, 32'h1));
        // lookups, including indexes that saturate
        directed.push_back(beat_row(MODE_LOOKUP, 8'd0, 16'h0, 16'h0, 16'h0, 24'h0, 32'd0,
                                    1'b1, 8'd0, 24'hFF0080));
        directed.push_back(beat_row(MODE_LOOKUP, 8'd0, 16'h0, 16'h0, 16'h0, 24'h0, 32'hFFFF_FFFF,
                                    1'b1, 8'd0, 24'h12AB00));
        directed.push_back(beat_row(MODE_LOOKUP, 8'd0, 16'h0, 16'h0, 16'h0, 24'h0, 32'd256,
                                    1'b1, 8'd0, 24'h12AB00));
        directed.push_back(beat_row(MODE_LOOKUP, 8'd0, 16'h0, 16'h0, 16'h0, 24'h0, 32'd1,
                                    1'b1, 8'd0, 24'h0));
        // nothing near white: no-match index
        directed.push_back(beat_row(MODE_MATCH, 8'd0, 16'h0, 16'h0, 16'h0, 24'hFFFFFF, 32'd0,
                                    1'b1, NO_MATCH_INDEX, 24'h0));
        // exact hit, then black where many zero entries tie
        directed.push_back(beat_row(MODE_MATCH, 8'd0, 16'h0, 16'h0, 16'h0, 24'hFF0080, 32'd0,
                                    1'b0, 8'd0, 24'h0));
        directed.push_back(beat_row(MODE_MATCH, 8'd0, 16'h0, 16'h0, 16'h0, 24'h000000, 32'd0,
                                    1'b0, 8'd0, 24'h0));
        // unused mode changes nothing
        directed.push_back(beat_row(MODE_UNUSED, 8'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF,
                                    32'hFFFF_FFFF, 1'b0, 8'd0, 24'h0));
        // entry 1 lies exactly on the distance limit from red 64, just inside from red 63
        directed.push_back(beat_row(MODE_WRITE, 8'd1, 16'h20FF, 16'h0000, 16'h0000, 24'h0, 32'd0,
                                    1'b0, 8'd0, 24'h0));
        directed.push_back(beat_row(MODE_MATCH, 8'd0, 16'h0, 16'h0, 16'h0, 24'h400000, 32'd0,
                                    1'b0, 8'd0, 24'h0));
        directed.push_back(beat_row(MODE_MATCH, 8'd0, 16'h0, 16'h0, 16'h0, 24'h3F0000, 32'd0,
                                    1'b0, 8'd0, 24'h0));
        // duplicate of entry 0 higher up: the lower index still wins
        directed.push_back(beat_row(MODE_WRITE, 8'd3, 16'hFF00, 16'h0000, 16'h80AA, 24'h0, 32'd0,
                                    1'b0, 8'd0, 24'h0));
        directed.push_back(beat_row(MODE_MATCH, 8'd0, 16'h0, 16'h0, 16'h0, 24'hFF0080, 32'd0,
                                    1'b0, 8'd0, 24'h0));
        // unmapped register slot is ignored
        directed.push_back(reg_row(ADDR_UNMAPPED, 32'h0));
        directed.push_back(beat_row(MODE_LOOKUP, 8'd0, 16'h0, 16'h0, 16'h0, 24'h0, 32'd0,
                                    1'b1, 8'd0, 24'hFF0080));
        // presence off with every other data bit set
        directed.push_back(reg_row(ADDR_PRESENT, 32'hFFFF_FFFE));
        directed.push_back(beat_row(MODE_MATCH, 8'd0, 16'h0, 16'h0, 16'h0, 24'hFF0080, 32'd0,
                                    1'b1, 8'd0, 24'h0));
        directed.push_back(beat_row(MODE_LOOKUP, 8'd0, 16'h0, 16'h0, 16'h0, 24'h0, 32'hFFFF_FFFF,
                                    1'b1, 8'd0, 24'h0));
        directed.push_back(reg_row(ADDR_PRESENT, 32'hFFFF_FFFF));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (directed[k]) begin
            if (directed[k].kind == ROW_REG)
                write_register(directed[k].addr, directed[k].wdata);
            else
                send_command(directed[k].cmd, directed[k].known, directed[k].answer);
        end

        // Random phases, each opened by a register write while idle
        beats = 0;
        phase = 0;
        while (beats < RANDOM_BEATS) begin
            // long stretch with no sender idling in the middle of the run
            idle_pct = (phase == 3 || phase == 4) ? 0 : 7;
            wdata    = $urandom;
            wdata[0] = (phase % 4 != 2);
            write_register(ADDR_PRESENT, wdata);
            if ($urandom_range(0, 1) == 1)
                write_register(ADDR_UNMAPPED, $urandom);
            phase_end = beats + RANDOM_BEATS / PHASES;
            while (beats < phase_end && beats < RANDOM_BEATS) begin
                cmd = random_command();
                send_command(cmd, 1'b0, '0);
                beats++;
            end
            phase++;
        end

        // Drain, then allow a full scan for anything stray
        settle_for_config();
        repeat (PALETTE_ENTRIES) @(posedge i_clk);
        if (errors == 0)
            $display("palette_nearest_colour_match_unit_tb passed");
        else
            $display("palette_nearest_colour_match_unit_tb failed");
        $finish;
    end

endmodule
